### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define CLCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must hold at every rising edge outside reset
`define CLCD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   `CLCD_ASSERT(label, clk, rst, cond, msg)

`endif

### rtl/clcd_pkg.sv
// package: types, codes, constants and helpers of the character lcd write sequencer
package clcd_pkg;

   localparam int SEQ_DEPTH_DEFAULT = 5;
   localparam int MAX_BURST         = 5;
   localparam int CMD_W             = 3;
   localparam int TICK_W            = 16;
   localparam int CSR_INDEX_W       = 2;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_POWER  = 3'd1,
      PH_UPPER  = 3'd2,
      PH_GAP    = 3'd3,
      PH_LOWER  = 3'd4,
      PH_SETTLE = 3'd5
   } phase_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK          = 3'd0,
      CMD_WRITE_COMMAND = 3'd1,
      CMD_WRITE_DATA    = 3'd2,
      CMD_INIT          = 3'd3,
      CMD_CLEAR         = 3'd4,
      CMD_SET_CURSOR    = 3'd5,
      CMD_HEX           = 3'd6
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE_PULSE = 2'd0,
      CSR_NIBBLE_GAP   = 2'd1,
      CSR_BYTE_SETTLE  = 2'd2,
      CSR_POWER_ON     = 2'd3
   } csr_index_type;

   // bit 8 register select, bits 7..0 byte
   typedef logic [8:0] entry_type;

   localparam logic [TICK_W-1:0] ENABLE_PULSE_RESET = 16'd1;
   localparam logic [TICK_W-1:0] NIBBLE_GAP_RESET   = 16'd200;
   localparam logic [TICK_W-1:0] BYTE_SETTLE_RESET  = 16'd2000;
   localparam logic [TICK_W-1:0] POWER_ON_RESET     = 16'd20000;

   localparam logic [7:0] LCD_RETURN_HOME = 8'h02;
   localparam logic [7:0] LCD_FUNC_SET    = 8'h28;
   localparam logic [7:0] LCD_DISPLAY_ON  = 8'h0C;
   localparam logic [7:0] LCD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] LCD_CLR_DISPLAY = 8'h01;
   localparam logic [7:0] LCD_ROW0_ADDR   = 8'h80;
   localparam logic [7:0] LCD_ROW1_ADDR   = 8'hC0;

   // ascii hex digit of a nibble, upper case
   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = 8'h30 + {4'd0, d};
      end else begin
         c = 8'h37 + {4'd0, d};
      end
      return c;
   endfunction

endpackage

### rtl/char_lcd_4bit_write_sequencer.sv
// top level: four-bit character lcd write sequencer
//
// req channel: one transaction per item. command 0 is a tick from the timebase,
// commands 1 to 6 are requests (write command, write data, init, clear,
// set cursor, hex). A request made while the sequencer is busy is refused.
// rsp channel: exactly one transaction per req transaction, in order, showing
// the lcd pin levels, pins_driven and busy after that item, plus accepted.
// csr port: timing registers in ticks; the user writes them only while idle, the block does not enforce it.
// A req transaction passes the input register, then the result register,
// before it leaves on rsp. Throughput: one item per cycle while rsp_stall
// is low; the whole state update is one pass of logic between both registers.
// When rsp_stall is high the result register holds; the input register still
// takes one more item, then req_stall rises until the result is taken.
// Reset clears the sequencer to idle with the pins low and the timing registers
// at their defaults; no rsp transaction is pending after reset.
module char_lcd_4bit_write_sequencer #(
   parameter int SEQUENCE_DEPTH = clcd_pkg::SEQ_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [clcd_pkg::CMD_W-1:0]       req_command,
   input  logic [7:0]                       req_value,
   input  logic [1:0]                       req_row,
   input  logic [4:0]                       req_column,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [3:0]                       rsp_data_nibble,
   output logic                             rsp_register_select,
   output logic                             rsp_enable,
   output logic                             rsp_pins_driven,
   output logic                             rsp_busy_res,
   output logic                             rsp_accepted,
   input  logic                             csr_write_enable,
   input  logic [clcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [clcd_pkg::TICK_W-1:0]      csr_write_data
);
   import clcd_pkg::*;

   localparam int CNT_W = $clog2(SEQUENCE_DEPTH + 1);
   localparam int SLOTS = (SEQUENCE_DEPTH > MAX_BURST) ? SEQUENCE_DEPTH : MAX_BURST;
   localparam logic [3:0] DEPTH_CNT = 4'(SEQUENCE_DEPTH);

   // timing registers
   logic [TICK_W-1:0] pulse_ff, gap_ff, settle_ff, power_ff;

   // input stage
   logic        s1_valid_ff, s1_valid_in;
   command_type s1_cmd_ff;
   logic [7:0]  s1_value_ff;
   logic [1:0]  s1_row_ff;
   logic [4:0]  s1_column_ff;
   logic        req_take;
   logic        advance;

   // sequencer state
   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] wait_ff, wait_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [3:0]        nibble_ff, nibble_in;
   logic              select_ff, select_in;
   logic              port_en_ff, port_en_in;
   entry_type         queue_ff [SEQUENCE_DEPTH];
   entry_type         queue_in [SEQUENCE_DEPTH];

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_nibble_ff;
   logic       rsp_select_ff, rsp_enable_ff, rsp_pins_ff, rsp_busy_ff, rsp_acc_ff;
   logic       acc;

   // request decode
   entry_type  burst [SLOTS];
   logic [3:0] burst_len;
   logic [3:0] burst_n;
   logic       burst_ok;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff  <= ENABLE_PULSE_RESET;
         gap_ff    <= NIBBLE_GAP_RESET;
         settle_ff <= BYTE_SETTLE_RESET;
         power_ff  <= POWER_ON_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE_PULSE: pulse_ff  <= csr_write_data;
            CSR_NIBBLE_GAP:   gap_ff    <= csr_write_data;
            CSR_BYTE_SETTLE:  settle_ff <= csr_write_data;
            CSR_POWER_ON:     power_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff    <= command_type'(req_command);
         s1_value_ff  <= req_value;
         s1_row_ff    <= req_row;
         s1_column_ff <= req_column;
      end
   end

   // bytes a request sends
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         burst[i] = '0;
      end
      burst_len = 4'd0;
      burst_ok  = 1'b1;
      case (s1_cmd_ff)
         CMD_WRITE_COMMAND: begin
            burst[0]  = {1'b0, s1_value_ff};
            burst_len = 4'd1;
         end
         CMD_WRITE_DATA: begin
            burst[0]  = {1'b1, s1_value_ff};
            burst_len = 4'd1;
         end
         CMD_INIT: begin
            burst[0]  = {1'b0, LCD_RETURN_HOME};
            burst[1]  = {1'b0, LCD_FUNC_SET};
            burst[2]  = {1'b0, LCD_DISPLAY_ON};
            burst[3]  = {1'b0, LCD_ENTRY_MODE};
            burst[4]  = {1'b0, LCD_CLR_DISPLAY};
            burst_len = 4'd5;
         end
         CMD_CLEAR: begin
            burst[0]  = {1'b0, LCD_CLR_DISPLAY};
            burst[1]  = {1'b0, LCD_RETURN_HOME};
            burst_len = 4'd2;
         end
         CMD_SET_CURSOR: begin
            burst[0]  = {1'b0, (s1_row_ff[0] ? LCD_ROW1_ADDR : LCD_ROW0_ADDR)
                               | {4'd0, s1_column_ff[3:0]}};
            burst_len = 4'd1;
            burst_ok  = (s1_row_ff <= 2'd1) && !s1_column_ff[4];
         end
         CMD_HEX: begin
            burst[0]  = {1'b1, hex_char(s1_value_ff[7:4])};
            burst[1]  = {1'b1, hex_char(s1_value_ff[3:0])};
            burst_len = 4'd2;
         end
         default: burst_ok = 1'b0;
      endcase
      burst_n = (burst_len > DEPTH_CNT) ? DEPTH_CNT : burst_len;
   end

   // next state and result
   always_comb begin
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      rem_in     = rem_ff;
      nibble_in  = nibble_ff;
      select_in  = select_ff;
      port_en_in = port_en_ff;
      acc        = 1'b0;
      for (int i = 0; i < SEQUENCE_DEPTH; i++) begin
         queue_in[i] = queue_ff[i];
      end
      if (advance) begin
         if (s1_cmd_ff == CMD_TICK) begin
            if (phase_ff != PH_IDLE) begin
               if (wait_ff > 16'd1) begin
                  wait_in = wait_ff - 16'd1;
               end else begin
                  case (phase_ff)
                     PH_POWER: begin
                        select_in = queue_ff[0][8];
                        nibble_in = queue_ff[0][7:4];
                        phase_in  = PH_UPPER;
                        wait_in   = pulse_ff;
                     end
                     PH_UPPER: begin
                        phase_in = PH_GAP;
                        wait_in  = gap_ff;
                     end
                     PH_GAP: begin
                        nibble_in = queue_ff[0][3:0];
                        phase_in  = PH_LOWER;
                        wait_in   = pulse_ff;
                     end
                     PH_LOWER: begin
                        phase_in = PH_SETTLE;
                        wait_in  = settle_ff;
                     end
                     PH_SETTLE: begin
                        if (rem_ff > CNT_W'(1)) begin
                           for (int i = 0; i < SEQUENCE_DEPTH - 1; i++) begin
                              queue_in[i] = queue_ff[i + 1];
                           end
                           rem_in    = rem_ff - CNT_W'(1);
                           select_in = queue_ff[1][8];
                           nibble_in = queue_ff[1][7:4];
                           phase_in  = PH_UPPER;
                           wait_in   = pulse_ff;
                        end else begin
                           phase_in = PH_IDLE;
                           wait_in  = '0;
                           rem_in   = '0;
                        end
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
         end else if (phase_ff == PH_IDLE && burst_ok) begin
            acc = 1'b1;
            for (int i = 0; i < SEQUENCE_DEPTH; i++) begin
               queue_in[i] = burst[i];
            end
            rem_in = CNT_W'(burst_n);
            if (s1_cmd_ff == CMD_INIT) begin
               port_en_in = 1'b1;
               phase_in   = PH_POWER;
               wait_in    = power_ff;
            end else begin
               select_in = burst[0][8];
               nibble_in = burst[0][7:4];
               phase_in  = PH_UPPER;
               wait_in   = pulse_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         wait_ff    <= '0;
         rem_ff     <= '0;
         nibble_ff  <= '0;
         select_ff  <= 1'b0;
         port_en_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         wait_ff    <= wait_in;
         rem_ff     <= rem_in;
         nibble_ff  <= nibble_in;
         select_ff  <= select_in;
         port_en_ff <= port_en_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SEQUENCE_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_nibble_ff <= nibble_in;
         rsp_select_ff <= select_in;
         rsp_enable_ff <= (phase_in == PH_UPPER) || (phase_in == PH_LOWER);
         rsp_pins_ff   <= port_en_in;
         rsp_busy_ff   <= (phase_in != PH_IDLE);
         rsp_acc_ff    <= acc;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data_nibble     = rsp_nibble_ff;
   assign rsp_register_select = rsp_select_ff;
   assign rsp_enable          = rsp_enable_ff;
   assign rsp_pins_driven     = rsp_pins_ff;
   assign rsp_busy_res        = rsp_busy_ff;
   assign rsp_accepted        = rsp_acc_ff;

endmodule

### rtl/clcd_checker.sv
// checker on the ports of the character lcd write sequencer, with its bind
`include "assert_macros.svh"

module clcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_data_nibble,
   input logic       rsp_enable,
   input logic       rsp_busy_res,
   input logic       rsp_accepted
);

   // a taken request always starts a wait or a byte
   `CLCD_ASSERT(acc_busy, clock, reset, rsp_valid && rsp_accepted |-> rsp_busy_res, "accepted request left the sequencer idle")

   // the strobe only pulses inside a sequence
   `CLCD_ASSERT(enable_busy, clock, reset, rsp_valid && rsp_enable |-> rsp_busy_res, "enable high while idle")

   // a stalled result transaction stays put
   `CLCD_ASSERT(rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_nibble) && $stable(rsp_enable), "stalled result changed")

endmodule

bind char_lcd_4bit_write_sequencer clcd_checker u_clcd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_data_nibble (rsp_data_nibble),
   .rsp_enable      (rsp_enable),
   .rsp_busy_res    (rsp_busy_res),
   .rsp_accepted    (rsp_accepted)
);
